// File: rtl/pfa_pkg.sv
// Shared types, codes and a helper function for the particle force accumulator.
// Used by the datapath, the controller and the top level; depends on nothing.
package pfa_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam logic [15:0] DAMP_RESET = 16'd5898;

  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_CLEAR      = 3'd1,
    OP_DAMP       = 3'd2,
    OP_REPEL_PT   = 3'd3,
    OP_ATTR_PT    = 3'd4,
    OP_REPEL_PAIR = 3'd5,
    OP_ATTR_PAIR  = 3'd6,
    OP_INTEGRATE  = 3'd7
  } op_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_RD_A,
    CMD_RD_B,
    CMD_GET_B,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_DAMP_MX,
    CMD_DAMP_MY,
    CMD_DAMP_FY,
    CMD_INT_V,
    CMD_INT_P,
    CMD_DIFF,
    CMD_SQ_X,
    CMD_SQ_Y,
    CMD_RR,
    CMD_SQRT_GO,
    CMD_LEN,
    CMD_DIV_P,
    CMD_PCT,
    CMD_DIV_X,
    CMD_DIV_Y,
    CMD_U,
    CMD_MUL1,
    CMD_MUL2,
    CMD_FX,
    CMD_FY,
    CMD_APPLY,
    CMD_WR_A,
    CMD_WR_B
  } cmd_e;

  typedef enum logic [5:0] {
    S_IDLE, S_RDA, S_RDB, S_DISP, S_LOAD, S_CLR,
    S_DAMPX, S_DAMPY, S_DAMPW, S_INTV, S_INTP,
    S_DIFF, S_CHK, S_SQX, S_SQY, S_RR, S_CMP, S_SQRTW,
    S_DIVP, S_DIVPW, S_DIVX, S_DIVXW, S_MX1, S_MX2, S_MX3,
    S_DIVY, S_DIVYW, S_MY1, S_MY2, S_MY3, S_APPLY, S_WRA, S_WRB, S_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               man;
  } particle_t;

  typedef struct packed {
    op_e  op;
    logic range_fail;
    logic cmp_fail;
    logic sqrt_busy;
    logic div_busy;
    logic pair_applied;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: rtl/pfa_sqrt.sv
// Iterative integer square root, one result bit per cycle for a 32-bit root.
// Uses no package items.
module pfa_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] n_q;
  logic [32:0] rem_q;
  logic [31:0] root_q;
  logic [34:0] r2, trial;
  logic        ge;

  assign r2     = {rem_q, n_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (r2 >= trial);
  assign busy_o = (cnt_q != 6'd0);
  assign root_o = root_q;

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = 6'd32;
    end else if (busy_o) begin
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_o) begin
      n_q    <= {n_q[61:0], 2'b00};
      rem_q  <= ge ? 33'(r2 - trial) : r2[32:0];
      root_q <= {root_q[30:0], ge};
    end
  end

endmodule

// File: rtl/pfa_div.sv
// Restoring divider giving floor((num << 16) / den) for num <= den, one bit per cycle.
// Uses no package items.
module pfa_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] num_i,
  input  logic [30:0] den_i,
  output logic        busy_o,
  output logic [16:0] quo_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, r;
  logic [30:0] den_q;
  logic [16:0] quo_q;
  logic        ge;

  assign ge     = (rem_q >= {1'b0, den_q});
  assign r      = ge ? rem_q - {1'b0, den_q} : rem_q;
  assign busy_o = (cnt_q != 5'd0);
  assign quo_o  = quo_q;

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = 5'd17;
    end else if (busy_o) begin
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_o) begin
      rem_q <= {r[30:0], 1'b0};
      quo_q <= {quo_q[15:0], ge};
    end
  end

endmodule

// File: rtl/pfa_dp.sv
// Datapath: particle memory, operand registers, multiplier, square root and divider.
// Depends on pfa_pkg, pfa_sqrt and pfa_div.
module pfa_dp #(
  parameter int unsigned PARTICLES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfa_pkg::cmd_e       cmd_i,
  output pfa_pkg::status_t    status_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [2:0]          operation_i,
  input  logic [5:0]          first_index_i,
  input  logic [5:0]          second_index_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  load_vel_x_i,
  input  logic signed [31:0]  load_vel_y_i,
  input  logic [30:0]         reach_i,
  input  logic signed [31:0]  strength_i,
  input  logic                manual_i,
  output logic [5:0]          particle_o,
  output logic signed [31:0]  pos_x_out_o,
  output logic signed [31:0]  pos_y_out_o,
  output logic signed [31:0]  vel_x_out_o,
  output logic signed [31:0]  vel_y_out_o,
  output logic signed [31:0]  force_x_out_o,
  output logic signed [31:0]  force_y_out_o,
  output logic                in_range_o
);
  import pfa_pkg::*;

  localparam int unsigned IW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  function automatic logic [63:0][IW-1:0] build_wrap();
    logic [63:0][IW-1:0] t;
    int unsigned r;
    for (int unsigned i = 0; i < 64; i++) begin
      r = i;
      while (r >= PARTICLES) r = r - PARTICLES;
      t[i] = IW'(r);
    end
    return t;
  endfunction

  localparam logic [63:0][IW-1:0] WRAP = build_wrap();

  particle_t mem [PARTICLES];
  particle_t rd_q, a_q, b_q;

  op_e                op_q;
  logic [IW-1:0]      ia_q, ib_q, raddr;
  logic signed [31:0] inx_q, iny_q, ivx_q, ivy_q, str_q;
  logic [30:0]        reach_q;
  logic               man_q, applied_q, pair, plus;
  logic [15:0]        gain_q;
  logic signed [32:0] dx_q, dy_q, fx_q, fy_q;
  logic signed [33:0] fa_x, fa_y;
  logic [32:0]        ax, ay;
  logic signed [48:0] damp_q;
  logic [63:0]        prod_q, sum_q, rr_q;
  logic [30:0]        len_q, div_num;
  logic [16:0]        pct_q, u_q, quo;
  logic [31:0]        smag, fmag, root;
  logic               sqrt_busy, div_busy, div_go;

  assign pair  = (op_q == OP_REPEL_PAIR) || (op_q == OP_ATTR_PAIR);
  assign plus  = (op_q == OP_REPEL_PT) || (op_q == OP_REPEL_PAIR);
  assign ax    = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ay    = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
  assign smag  = str_q[31] ? 32'(-str_q) : 32'(str_q);
  assign fmag  = prod_q[47:16];
  assign fa_x  = plus ? 34'(fx_q) : -34'(fx_q);
  assign fa_y  = plus ? 34'(fy_q) : -34'(fy_q);
  assign raddr = (cmd_i == CMD_RD_B) ? ib_q : ia_q;

  always_comb begin
    case (cmd_i)
      CMD_DIV_P: div_num = reach_q - len_q;
      CMD_DIV_Y: div_num = ay[30:0];
      default:   div_num = ax[30:0];
    endcase
  end

  assign div_go = (cmd_i == CMD_DIV_P) || (cmd_i == CMD_DIV_X) || (cmd_i == CMD_DIV_Y);

  pfa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i == CMD_SQRT_GO),
    .rad_i   (sum_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  pfa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .den_i   ((cmd_i == CMD_DIV_P) ? reach_q : len_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  always_comb begin
    status_o.op           = op_q;
    status_o.range_fail   = (reach_q == 31'd0) || (ax > {2'b00, reach_q})
                            || (ay > {2'b00, reach_q});
    status_o.cmp_fail     = (sum_q == 64'd0) || (pair ? (sum_q > rr_q) : (sum_q >= rr_q));
    status_o.sqrt_busy    = sqrt_busy;
    status_o.div_busy     = div_busy;
    status_o.pair_applied = applied_q && pair;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= DAMP_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
    if (cmd_i == CMD_WR_A) begin
      mem[ia_q] <= a_q;
    end else if (cmd_i == CMD_WR_B) begin
      mem[ib_q] <= b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH: begin
        op_q      <= op_e'(operation_i);
        ia_q      <= WRAP[first_index_i];
        ib_q      <= WRAP[second_index_i];
        inx_q     <= point_x_i;
        iny_q     <= point_y_i;
        ivx_q     <= load_vel_x_i;
        ivy_q     <= load_vel_y_i;
        reach_q   <= reach_i;
        str_q     <= strength_i;
        man_q     <= manual_i;
        applied_q <= 1'b0;
      end
      CMD_RD_B:  a_q <= rd_q;
      CMD_GET_B: b_q <= rd_q;
      CMD_LOAD: begin
        a_q.px  <= inx_q;
        a_q.py  <= iny_q;
        a_q.vx  <= ivx_q;
        a_q.vy  <= ivy_q;
        a_q.man <= man_q;
      end
      CMD_CLEAR: begin
        a_q.fx <= '0;
        a_q.fy <= '0;
      end
      CMD_DAMP_MX: damp_q <= a_q.vx * $signed({1'b0, gain_q});
      CMD_DAMP_MY: begin
        a_q.fx <= sat32(35'(a_q.fx) - 35'(damp_q >>> FRAC_BITS));
        damp_q <= a_q.vy * $signed({1'b0, gain_q});
      end
      CMD_DAMP_FY: a_q.fy <= sat32(35'(a_q.fy) - 35'(damp_q >>> FRAC_BITS));
      CMD_INT_V: begin
        if (!a_q.man) begin
          a_q.vx <= sat32(35'(a_q.vx) + 35'(a_q.fx));
          a_q.vy <= sat32(35'(a_q.vy) + 35'(a_q.fy));
        end
      end
      CMD_INT_P: begin
        if (!a_q.man) begin
          a_q.px <= sat32(35'(a_q.px) + 35'(a_q.vx));
          a_q.py <= sat32(35'(a_q.py) + 35'(a_q.vy));
        end
      end
      CMD_DIFF: begin
        dx_q <= 33'(a_q.px) - 33'(pair ? b_q.px : inx_q);
        dy_q <= 33'(a_q.py) - 33'(pair ? b_q.py : iny_q);
      end
      CMD_SQ_X: prod_q <= 64'(ax[30:0]) * 64'(ax[30:0]);
      CMD_SQ_Y: begin
        sum_q  <= prod_q;
        prod_q <= 64'(ay[30:0]) * 64'(ay[30:0]);
      end
      CMD_RR: begin
        sum_q <= sum_q + prod_q;
        rr_q  <= 64'(reach_q) * 64'(reach_q);
      end
      CMD_LEN:  len_q <= root[30:0];
      CMD_PCT:  pct_q <= quo;
      CMD_U:    u_q <= quo;
      CMD_MUL1: prod_q <= 64'(u_q) * 64'(pct_q);
      CMD_MUL2: prod_q <= 64'(prod_q[32:16]) * 64'(smag);
      CMD_FX:   fx_q <= (dx_q[32] ^ str_q[31]) ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
      CMD_FY:   fy_q <= (dy_q[32] ^ str_q[31]) ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
      CMD_APPLY: begin
        a_q.fx    <= sat32(35'(a_q.fx) + 35'(fa_x));
        a_q.fy    <= sat32(35'(a_q.fy) + 35'(fa_y));
        b_q.fx    <= sat32(35'(b_q.fx) - 35'(fa_x));
        b_q.fy    <= sat32(35'(b_q.fy) - 35'(fa_y));
        applied_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign particle_o    = 6'(ia_q);
  assign pos_x_out_o   = a_q.px;
  assign pos_y_out_o   = a_q.py;
  assign vel_x_out_o   = a_q.vx;
  assign vel_y_out_o   = a_q.vy;
  assign force_x_out_o = a_q.fx;
  assign force_y_out_o = a_q.fy;
  assign in_range_o    = applied_q;

endmodule

// File: rtl/pfa_ctrl.sv
// Controller state machine that sequences the datapath for each operation.
// Depends on pfa_pkg.
module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  pfa_pkg::status_t  status_i,
  output pfa_pkg::cmd_e     cmd_o,
  output logic              busy,
  output logic              done_o
);
  import pfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = CMD_LATCH;
          state_d = S_RDA;
        end
      end
      S_RDA: begin
        cmd_o   = CMD_RD_A;
        state_d = S_RDB;
      end
      S_RDB: begin
        cmd_o   = CMD_RD_B;
        state_d = S_DISP;
      end
      S_DISP: begin
        cmd_o = CMD_GET_B;
        case (status_i.op)
          OP_LOAD:      state_d = S_LOAD;
          OP_CLEAR:     state_d = S_CLR;
          OP_DAMP:      state_d = S_DAMPX;
          OP_INTEGRATE: state_d = S_INTV;
          default:      state_d = S_DIFF;
        endcase
      end
      S_LOAD: begin
        cmd_o   = CMD_LOAD;
        state_d = S_WRA;
      end
      S_CLR: begin
        cmd_o   = CMD_CLEAR;
        state_d = S_WRA;
      end
      S_DAMPX: begin
        cmd_o   = CMD_DAMP_MX;
        state_d = S_DAMPY;
      end
      S_DAMPY: begin
        cmd_o   = CMD_DAMP_MY;
        state_d = S_DAMPW;
      end
      S_DAMPW: begin
        cmd_o   = CMD_DAMP_FY;
        state_d = S_WRA;
      end
      S_INTV: begin
        cmd_o   = CMD_INT_V;
        state_d = S_INTP;
      end
      S_INTP: begin
        cmd_o   = CMD_INT_P;
        state_d = S_WRA;
      end
      S_DIFF: begin
        cmd_o   = CMD_DIFF;
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = status_i.range_fail ? S_WRA : S_SQX;
      end
      S_SQX: begin
        cmd_o   = CMD_SQ_X;
        state_d = S_SQY;
      end
      S_SQY: begin
        cmd_o   = CMD_SQ_Y;
        state_d = S_RR;
      end
      S_RR: begin
        cmd_o   = CMD_RR;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (status_i.cmp_fail) begin
          state_d = S_WRA;
        end else begin
          cmd_o   = CMD_SQRT_GO;
          state_d = S_SQRTW;
        end
      end
      S_SQRTW: begin
        if (!status_i.sqrt_busy) begin
          cmd_o   = CMD_LEN;
          state_d = S_DIVP;
        end
      end
      S_DIVP: begin
        cmd_o   = CMD_DIV_P;
        state_d = S_DIVPW;
      end
      S_DIVPW: begin
        if (!status_i.div_busy) begin
          cmd_o   = CMD_PCT;
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd_o   = CMD_DIV_X;
        state_d = S_DIVXW;
      end
      S_DIVXW: begin
        if (!status_i.div_busy) begin
          cmd_o   = CMD_U;
          state_d = S_MX1;
        end
      end
      S_MX1: begin
        cmd_o   = CMD_MUL1;
        state_d = S_MX2;
      end
      S_MX2: begin
        cmd_o   = CMD_MUL2;
        state_d = S_MX3;
      end
      S_MX3: begin
        cmd_o   = CMD_FX;
        state_d = S_DIVY;
      end
      S_DIVY: begin
        cmd_o   = CMD_DIV_Y;
        state_d = S_DIVYW;
      end
      S_DIVYW: begin
        if (!status_i.div_busy) begin
          cmd_o   = CMD_U;
          state_d = S_MY1;
        end
      end
      S_MY1: begin
        cmd_o   = CMD_MUL1;
        state_d = S_MY2;
      end
      S_MY2: begin
        cmd_o   = CMD_MUL2;
        state_d = S_MY3;
      end
      S_MY3: begin
        cmd_o   = CMD_FY;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o   = CMD_APPLY;
        state_d = S_WRA;
      end
      S_WRA: begin
        cmd_o   = CMD_WR_A;
        state_d = status_i.pair_applied ? S_WRB : S_DONE;
      end
      S_WRB: begin
        cmd_o   = CMD_WR_B;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/particle_force_accumulator.sv
// Top level of the particle force accumulator: controller plus datapath.
// Depends on pfa_pkg, pfa_ctrl and pfa_dp.
//
// An operation is taken on a rising edge where start is high and busy is low.
// The block then works on that one operation and raises done_o for exactly one
// cycle while the result ports show the first particle after the operation;
// the transfer completes at the edge that ends that cycle and cannot be held
// off. Busy falls in the following cycle, so the block is idle between results.
// Load and clear pass through the fewest states, then integrate, then damping.
// A point or pair force that is out of range ends before the square root; one
// that applies waits on the square root and the three divisions, which run one
// after another, and a pair that applies also writes its second particle.
// The user must write the damping gain through cfg_we_i and cfg_wdata_i only
// while idle; the block does not enforce this. Reset returns the controller to
// idle and the gain to 0.09; the particle memory is not cleared and must be
// loaded before it is used.
module particle_force_accumulator #(
  parameter int unsigned PARTICLES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [2:0]          operation_i,
  input  logic [5:0]          first_index_i,
  input  logic [5:0]          second_index_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  load_vel_x_i,
  input  logic signed [31:0]  load_vel_y_i,
  input  logic [30:0]         reach_i,
  input  logic signed [31:0]  strength_i,
  input  logic                manual_i,
  output logic [5:0]          particle_o,
  output logic signed [31:0]  pos_x_out_o,
  output logic signed [31:0]  pos_y_out_o,
  output logic signed [31:0]  vel_x_out_o,
  output logic signed [31:0]  vel_y_out_o,
  output logic signed [31:0]  force_x_out_o,
  output logic signed [31:0]  force_y_out_o,
  output logic                in_range_o
);
  import pfa_pkg::*;

  cmd_e    cmd;
  status_t status;

  pfa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  pfa_dp #(
    .PARTICLES (PARTICLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .first_index_i  (first_index_i),
    .second_index_i (second_index_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .load_vel_x_i   (load_vel_x_i),
    .load_vel_y_i   (load_vel_y_i),
    .reach_i        (reach_i),
    .strength_i     (strength_i),
    .manual_i       (manual_i),
    .particle_o     (particle_o),
    .pos_x_out_o    (pos_x_out_o),
    .pos_y_out_o    (pos_y_out_o),
    .vel_x_out_o    (vel_x_out_o),
    .vel_y_out_o    (vel_y_out_o),
    .force_x_out_o  (force_x_out_o),
    .force_y_out_o  (force_y_out_o),
    .in_range_o     (in_range_o)
  );

endmodule
